// ===== rtl/core/multi_channel_timeout_manager_assert.svh =====
// ----------------------------------------------------------------------------
// Timeout manager assertion macros
// Shared property wrappers, clocked on i_clk, off during reset.
// ----------------------------------------------------------------------------
`ifndef MULTI_CHANNEL_TIMEOUT_MANAGER_ASSERT_SVH
`define MULTI_CHANNEL_TIMEOUT_MANAGER_ASSERT_SVH

// same-cycle implication
`define MCTM_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("mctm check failed");

// next-cycle implication
`define MCTM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("mctm check failed");

`endif

// ===== rtl/core/mctm_pkg.sv =====
// ----------------------------------------------------------------------------
// Timeout manager package
// Constants, codes, state types and the muldiv request/response structs.
// ----------------------------------------------------------------------------
package mctm_pkg;

    localparam int NUM_CHANNELS = 6;
    localparam int CH_IDX_W     = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int CH_CNT_W     = $clog2(NUM_CHANNELS + 1);

    localparam logic [31:0] NS_PER_S = 32'd1000000000;
    localparam logic [31:0] HZ_RESET = 32'd62500000;
    localparam logic [63:0] ALL_ONES = {64{1'b1}};

    // request codes
    localparam logic [1:0] REQ_CMP_IRQ  = 2'd0;
    localparam logic [1:0] REQ_GET_TIME = 2'd1;
    localparam logic [1:0] REQ_SET_TMO  = 2'd2;

    // result kinds
    localparam logic KIND_NOTIFY = 1'b0;
    localparam logic KIND_DONE   = 1'b1;

    typedef enum logic [1:0] {
        MD_IDLE,
        MD_MUL,
        MD_DIV,
        MD_DONE
    } t_md_state;

    typedef enum logic [2:0] {
        MC_IDLE,
        MC_NOW,
        MC_SCAN,
        MC_CMP,
        MC_EMIT
    } t_mc_state;

    typedef struct packed {
        logic        start;
        logic [63:0] a;
        logic [31:0] b;
        logic [31:0] d;
    } t_md_req;

    typedef struct packed {
        logic        done;
        logic [63:0] q;
    } t_md_rsp;

endpackage

// ===== rtl/core/multi_channel_timeout_manager.sv =====
// ----------------------------------------------------------------------------
// Multi-channel timeout manager
// Per-channel ns deadlines and a cycle compare value, driven by requests.
//
//  channel | dir | tdata (low bit up)                         | tuser    | tlast
//  s       | in  | channel, offset_ns, now_cycles             | req_type | -
//  m       | out | notify_channel, time_ns, compare_cycles    | kind     | last
//  cfg     | in  | timer_freq_hz on i_cfg_wr_data when wr_en  | -        | -
//
// Each conversion runs on one shared multiply-divide unit: 32 multiply
// steps, then 64 divide steps unless the product overflows. Get time takes
// one conversion; set timeout and compare interrupt add a scan of the
// six-entry table, a second conversion when a deadline remains, and a walk
// over the channels that emits their results. A stalled output holds results
// in the output register; the next request is taken once the previous one
// has loaded its last result into that register. Reset is synchronous.
// ----------------------------------------------------------------------------
`include "multi_channel_timeout_manager_assert.svh"

module multi_channel_timeout_manager
    import mctm_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_wr_en,
    input  logic [31:0]  i_cfg_wr_data,  // timer_freq_hz
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    input  logic [135:0] i_s_tdata,      // channel[2:0], offset_ns[66:3], now_cycles[130:67]
    input  logic [1:0]   i_s_tuser,      // req_type
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    output logic [135:0] o_m_tdata,      // notify_channel[2:0], time_ns[66:3],
                                         // compare_cycles[130:67]
    output logic [0:0]   o_m_tuser,      // kind
    output logic         o_m_tlast
);

    t_mc_state r_state, n_state;

    logic [31:0] r_hz;
    logic [63:0] r_table [NUM_CHANNELS];
    logic [63:0] r_cmp;
    logic [63:0] r_now;
    logic [63:0] r_off;
    logic [2:0]  r_ch;
    logic [1:0]  r_req;
    logic [63:0] r_next;
    logic [NUM_CHANNELS-1:0] r_exp;
    logic [CH_CNT_W-1:0]     r_idx;

    logic        r_out_valid;
    logic        r_out_kind;
    logic [2:0]  r_out_ch;
    logic [63:0] r_out_time;
    logic [63:0] r_out_cmp;
    logic        r_out_last;

    t_md_req md_req;
    t_md_rsp md_rsp;

    logic        accept;
    logic [31:0] eff_hz;
    logic [63:0] cur_entry;
    logic        cur_expire;
    logic [63:0] cur_min;
    logic        scan_last;
    logic        slot_free;
    logic        emit_end;
    logic        out_load;
    logic        do_scan;
    logic        ch_ok;
    logic [64:0] dl_sum;
    logic [63:0] dl_sat;

    // shared conversion unit
    mctm_muldiv u_muldiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (md_req),
        .o_rsp   (md_rsp)
    );

    // request decode and scan terms
    always_comb begin
        eff_hz     = (r_hz == 32'd0) ? 32'd1 : r_hz;
        accept     = i_s_tvalid && o_s_tready;
        cur_entry  = r_table[r_idx[CH_IDX_W-1:0]];
        cur_expire = (cur_entry != ALL_ONES) && (cur_entry <= r_now);
        cur_min    = (!cur_expire && (cur_entry < r_next)) ? cur_entry : r_next;
        scan_last  = (r_idx == CH_CNT_W'(NUM_CHANNELS - 1));
        slot_free  = !r_out_valid || i_m_tready;
        emit_end   = (r_idx == CH_CNT_W'(NUM_CHANNELS));
        out_load   = (r_state == MC_EMIT) && slot_free &&
                     (emit_end || r_exp[r_idx[CH_IDX_W-1:0]]);
        do_scan    = (r_req == REQ_CMP_IRQ) || (r_req == REQ_SET_TMO);
        ch_ok      = ({4'd0, r_ch} < 7'(NUM_CHANNELS));
        dl_sum     = {1'b0, md_rsp.q} + {1'b0, r_off};
        dl_sat     = dl_sum[64] ? ALL_ONES : dl_sum[63:0];
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            MC_IDLE: if (accept) n_state = MC_NOW;
            MC_NOW:  if (md_rsp.done) n_state = do_scan ? MC_SCAN : MC_EMIT;
            MC_SCAN: if (scan_last) n_state = (cur_min != ALL_ONES) ? MC_CMP : MC_EMIT;
            MC_CMP:  if (md_rsp.done) n_state = MC_EMIT;
            MC_EMIT: if (slot_free && emit_end) n_state = MC_IDLE;
            default: n_state = MC_IDLE;
        endcase
    end

    // outputs and unit requests
    always_comb begin
        o_s_tready   = (r_state == MC_IDLE);
        md_req.start = (r_state == MC_IDLE && accept) ||
                       (r_state == MC_SCAN && scan_last && cur_min != ALL_ONES);
        md_req.a     = (r_state == MC_IDLE) ? i_s_tdata[130:67] : cur_min;
        md_req.b     = (r_state == MC_IDLE) ? NS_PER_S : eff_hz;
        md_req.d     = (r_state == MC_IDLE) ? eff_hz : NS_PER_S;
        o_m_tvalid   = r_out_valid;
        o_m_tdata    = {5'd0, r_out_cmp, r_out_time, r_out_ch};
        o_m_tuser    = r_out_kind;
        o_m_tlast    = r_out_last;
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= MC_IDLE;
            r_hz        <= HZ_RESET;
            r_cmp       <= ALL_ONES;
            r_out_valid <= 1'b0;
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                r_table[i] <= ALL_ONES;
            end
        end else begin
            r_state <= n_state;
            if (i_cfg_wr_en) begin
                r_hz <= i_cfg_wr_data;
            end
            // output slot: load a new item or drop the accepted one
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                MC_NOW: begin
                    if (md_rsp.done) begin
                        if (r_req == REQ_CMP_IRQ) begin
                            r_cmp <= ALL_ONES;
                        end
                        for (int i = 0; i < NUM_CHANNELS; i++) begin
                            if (r_req == REQ_SET_TMO && ch_ok && 32'(r_ch) == i) begin
                                r_table[i] <= dl_sat;
                            end
                        end
                    end
                end
                MC_SCAN: begin
                    if (cur_expire) begin
                        r_table[r_idx[CH_IDX_W-1:0]] <= ALL_ONES;
                    end
                end
                MC_CMP: begin
                    if (md_rsp.done) begin
                        r_cmp <= md_rsp.q;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            MC_IDLE: begin
                if (accept) begin
                    r_req <= i_s_tuser;
                    r_ch  <= i_s_tdata[2:0];
                    r_off <= i_s_tdata[66:3];
                end
            end
            MC_NOW: begin
                if (md_rsp.done) begin
                    r_now  <= md_rsp.q;
                    r_next <= ALL_ONES;
                    r_exp  <= '0;
                    r_idx  <= '0;
                end
            end
            MC_SCAN: begin
                r_next <= cur_min;
                r_exp[r_idx[CH_IDX_W-1:0]] <= cur_expire;
                r_idx  <= scan_last ? '0 : r_idx + CH_CNT_W'(1);
            end
            MC_EMIT: begin
                if (slot_free) begin
                    r_out_time <= r_now;
                    r_out_cmp  <= r_cmp;
                    if (emit_end) begin
                        r_out_kind <= KIND_DONE;
                        r_out_ch   <= 3'd0;
                        r_out_last <= 1'b1;
                    end else begin
                        r_out_kind <= KIND_NOTIFY;
                        r_out_ch   <= 3'(r_idx);
                        r_out_last <= 1'b0;
                        r_idx      <= r_idx + CH_CNT_W'(1);
                    end
                end
            end
            default: begin
            end
        endcase
    end

    `MCTM_ASSERT_NOW(a_done_in_wait, md_rsp.done, r_state == MC_NOW || r_state == MC_CMP)
    `MCTM_ASSERT_NOW(a_last_is_done, o_m_tvalid, o_m_tlast == (o_m_tuser[0] == KIND_DONE))
    `MCTM_ASSERT_NOW(a_scan_kind, r_state == MC_SCAN,
                     r_req == REQ_CMP_IRQ || r_req == REQ_SET_TMO)

endmodule

// ===== rtl/core/mctm_muldiv.sv =====
// ----------------------------------------------------------------------------
// Timeout manager multiply-divide unit
// floor(a * b / d) saturated at all ones; one shift-add step per cycle for
// the product, then one restoring divide step per cycle.
// ----------------------------------------------------------------------------
`include "multi_channel_timeout_manager_assert.svh"

module mctm_muldiv
    import mctm_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_md_req i_req,
    output t_md_rsp o_rsp
);

    t_md_state   r_state, n_state;
    logic [95:0] r_acc;      // {hi/rem, lo/quotient} or {partial, multiplier}
    logic [63:0] r_mcand;
    logic [31:0] r_div;
    logic [6:0]  r_cnt;

    logic [64:0] mul_sum;
    logic [32:0] div_trial;
    logic        div_ge;
    logic        mul_last;
    logic        div_last;
    logic        hi_ovf;

    // datapath terms
    always_comb begin
        mul_sum   = {1'b0, r_acc[95:32]} + (r_acc[0] ? {1'b0, r_mcand} : 65'd0);
        div_trial = {r_acc[95:64], r_acc[63]};
        div_ge    = (div_trial >= {1'b0, r_div});
        mul_last  = (r_cnt == 7'd31);
        div_last  = (r_cnt == 7'd63);
        hi_ovf    = (mul_sum[64:33] >= r_div);
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            MD_IDLE: if (i_req.start) n_state = MD_MUL;
            MD_MUL:  if (mul_last) n_state = hi_ovf ? MD_DONE : MD_DIV;
            MD_DIV:  if (div_last) n_state = MD_DONE;
            MD_DONE: n_state = MD_IDLE;
            default: n_state = MD_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_rsp.done = (r_state == MD_DONE);
        o_rsp.q    = r_acc[63:0];
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= MD_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // shift-add and compare-subtract steps
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            MD_IDLE: begin
                r_acc   <= {64'd0, i_req.b};
                r_mcand <= i_req.a;
                r_div   <= i_req.d;
                r_cnt   <= 7'd0;
            end
            MD_MUL: begin
                r_cnt <= mul_last ? 7'd0 : r_cnt + 7'd1;
                if (mul_last && hi_ovf) begin
                    r_acc <= {mul_sum[64:33], ALL_ONES};
                end else begin
                    r_acc <= {mul_sum, r_acc[31:1]};
                end
            end
            MD_DIV: begin
                r_cnt <= r_cnt + 7'd1;
                if (div_ge) begin
                    r_acc <= {32'(div_trial - {1'b0, r_div}), r_acc[62:0], 1'b1};
                end else begin
                    r_acc <= {div_trial[31:0], r_acc[62:0], 1'b0};
                end
            end
            MD_DONE: begin
                r_cnt <= 7'd0;
            end
            default: begin
                r_cnt <= 7'd0;
            end
        endcase
    end

    `MCTM_ASSERT_NOW(a_rem_below_div, r_state == MD_DIV, r_acc[95:64] < r_div)
    `MCTM_ASSERT_NEXT(a_done_one_cycle, r_state == MD_DONE, r_state == MD_IDLE)

endmodule

// ===== test/multi_channel_timeout_manager_tb.sv =====
// ----------------------------------------------------------------------------
// Timeout manager testbench
// Drives timer requests over the input stream with random gaps and output
// stalls. A local timer predictor keeps its own deadline table and compare
// value, and every result item is checked field by field against it.
// ----------------------------------------------------------------------------
module multi_channel_timeout_manager_tb;
    import mctm_pkg::*;

    localparam logic [63:0] ONES64 = {64{1'b1}};
    localparam logic [1:0]  REQ_BAD = 2'd3;

    typedef struct packed {
        logic        kind;
        logic [2:0]  chan;
        logic [63:0] time_ns;
        logic [63:0] cmp;
        logic        last;
    } t_result;

    typedef struct {
        logic [1:0]  req;
        logic [2:0]  chan;
        logic [63:0] off;
        logic [63:0] now;
        logic        chk;      // typed-in done result follows
        logic [63:0] t_ns;
        logic [63:0] cmp;
    } t_row;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_cfg_wr_en = 1'b0;
    logic [31:0]  i_cfg_wr_data = '0;
    logic         i_s_tvalid = 1'b0;
    logic         o_s_tready;
    logic [135:0] i_s_tdata = '0;
    logic [1:0]   i_s_tuser = '0;
    logic         o_m_tvalid;
    logic         i_m_tready = 1'b0;
    logic [135:0] o_m_tdata;
    logic [0:0]   o_m_tuser;
    logic         o_m_tlast;

    multi_channel_timeout_manager DUT (.*);

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // predictor state
    logic [31:0] freq_hz;
    logic [63:0] deadlines [NUM_CHANNELS];
    logic [63:0] compare_val;
    t_result     pending_results [$];
    int          errors = 0;
    int          n_items = 0;
    int          n_notify = 0;
    int          n_results = 0;
    bit          quiet_phase = 0;

    // floor(a * b / d) saturated at 64 bits
    function automatic logic [63:0] scale_sat(logic [63:0] a, logic [63:0] b,
                                              logic [63:0] d);
        logic [127:0] q;
        q = ({64'd0, a} * {64'd0, b}) / {64'd0, d};
        return (q[127:64] != 0) ? ONES64 : q[63:0];
    endfunction

    task automatic predict_request(logic [1:0] req, logic [2:0] ch,
                                   logic [63:0] off, logic [63:0] cyc);
        logic [63:0] hz, now_ns, nearest, total;
        logic [64:0] sum;
        bit          fired [NUM_CHANNELS];
        t_result     r;
        hz = (freq_hz == 0) ? 64'd1 : {32'd0, freq_hz};
        now_ns = scale_sat(cyc, 64'd1000000000, hz);
        foreach (fired[i]) fired[i] = 0;
        if (req == REQ_CMP_IRQ || req == REQ_SET_TMO) begin
            nearest = ONES64;
            if (req == REQ_CMP_IRQ) begin
                compare_val = ONES64;
            end else if (ch < NUM_CHANNELS) begin
                sum = {1'b0, now_ns} + {1'b0, off};
                total = sum[64] ? ONES64 : sum[63:0];
                deadlines[ch] = total;
            end
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                if (deadlines[i] != ONES64 && deadlines[i] <= now_ns) begin
                    fired[i] = 1;
                    deadlines[i] = ONES64;
                end
            end
            for (int i = 0; i < NUM_CHANNELS; i++)
                if (deadlines[i] < nearest) nearest = deadlines[i];
            if (nearest != ONES64) compare_val = scale_sat(nearest, hz, 64'd1000000000);
        end
        for (int i = 0; i < NUM_CHANNELS; i++) begin
            if (fired[i]) begin
                r = '{KIND_NOTIFY, 3'(i), now_ns, compare_val, 1'b0};
                pending_results.push_back(r);
            end
        end
        r = '{KIND_DONE, 3'd0, now_ns, compare_val, 1'b1};
        pending_results.push_back(r);
    endtask

    // output side: random stall bursts, check every accepted item
    always @(posedge i_clk) begin
        t_result got, exp_r;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got = '{o_m_tuser[0], o_m_tdata[2:0], o_m_tdata[66:3],
                    o_m_tdata[130:67], o_m_tlast};
            n_results++;
            if (got.kind == KIND_NOTIFY) n_notify++;
            if (pending_results.size() == 0) begin
                errors++;
                $display("%0t: unexpected result %h", $realtime, got);
            end else begin
                exp_r = pending_results.pop_front();
                if (got.kind !== exp_r.kind)
                    $display("%0t: kind exp %0d got %0d", $realtime, exp_r.kind, got.kind);
                if (got.chan !== exp_r.chan)
                    $display("%0t: channel exp %0d got %0d", $realtime, exp_r.chan, got.chan);
                if (got.time_ns !== exp_r.time_ns)
                    $display("%0t: time_ns exp %h got %h", $realtime, exp_r.time_ns,
                             got.time_ns);
                if (got.cmp !== exp_r.cmp)
                    $display("%0t: compare exp %h got %h", $realtime, exp_r.cmp, got.cmp);
                if (got.last !== exp_r.last)
                    $display("%0t: last exp %0d got %0d", $realtime, exp_r.last, got.last);
                if (got !== exp_r) errors++;
            end
        end
    end

    int stall_left = 0;
    always @(posedge i_clk) begin
        if (quiet_phase) begin
            i_m_tready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_m_tready <= 1'b0;
        end else if ($urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(1, 19);
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= 1'b1;
        end
    end

    task automatic write_freq(logic [31:0] hz);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_wr_data <= hz;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        freq_hz = hz;
    endtask

    // wait for all results, then let the block settle before a register write
    task automatic drain();
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
    endtask

    // one request; the predictor runs at acceptance
    task automatic send_request(logic [1:0] req, logic [2:0] ch, logic [63:0] off,
                                logic [63:0] cyc);
        int gap;
        if (!quiet_phase && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 19);
            repeat (gap) @(posedge i_clk);
        end else begin
            // block is busy right after an accept, so this costs no rate
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser <= req;
        i_s_tdata <= {5'd0, cyc, off, ch};
        do @(posedge i_clk); while (!o_s_tready);
        predict_request(req, ch, off, cyc);
        i_s_tvalid <= 1'b0;
        n_items++;
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // directed rows at the reset frequency (62.5 MHz: 16 ns per cycle)
    t_row directed [] = '{
        '{REQ_GET_TIME, 3'd0, 64'd0, 64'd0, 1'b1, 64'd0, ONES64},
        '{REQ_GET_TIME, 3'd0, 64'd0, 64'd100, 1'b1, 64'd1600, ONES64},
        '{REQ_GET_TIME, 3'd7, ONES64, ONES64, 1'b1, ONES64, ONES64},
        '{REQ_BAD, 3'd5, ONES64, 64'd1, 1'b1, 64'd16, ONES64},
        '{REQ_CMP_IRQ, 3'd0, 64'd0, 64'd10, 1'b1, 64'd160, ONES64},
        '{REQ_SET_TMO, 3'd0, 64'd1600, 64'd0, 1'b0, 64'd0, 64'd0},
        '{REQ_SET_TMO, 3'd1, 64'd3200, 64'd0, 1'b0, 64'd0, 64'd0},
        '{REQ_SET_TMO, 3'd5, ONES64, 64'd10, 1'b0, 64'd0, 64'd0},
        '{REQ_SET_TMO, 3'd6, 64'd5, 64'd20, 1'b0, 64'd0, 64'd0},
        '{REQ_SET_TMO, 3'd7, 64'd5, 64'd40, 1'b0, 64'd0, 64'd0},
        '{REQ_SET_TMO, 3'd2, 64'd0, 64'd300, 1'b0, 64'd0, 64'd0},
        '{REQ_SET_TMO, 3'd3, 64'd0, ONES64, 1'b0, 64'd0, 64'd0},
        '{REQ_SET_TMO, 3'd0, 64'd50, 64'd1000, 1'b0, 64'd0, 64'd0},
        '{REQ_SET_TMO, 3'd1, 64'd70, 64'd1000, 1'b0, 64'd0, 64'd0},
        '{REQ_SET_TMO, 3'd2, 64'd90, 64'd1000, 1'b0, 64'd0, 64'd0},
        '{REQ_SET_TMO, 3'd3, 64'd110, 64'd1000, 1'b0, 64'd0, 64'd0},
        '{REQ_SET_TMO, 3'd4, 64'd130, 64'd1000, 1'b0, 64'd0, 64'd0},
        '{REQ_SET_TMO, 3'd5, 64'd150, 64'd1000, 1'b0, 64'd0, 64'd0},
        '{REQ_CMP_IRQ, 3'd0, 64'd0, 64'd2000, 1'b0, 64'd0, 64'd0},
        '{REQ_SET_TMO, 3'd4, 64'h8000_0000_0000_0000, 64'd5, 1'b0, 64'd0, 64'd0},
        '{REQ_CMP_IRQ, 3'd0, 64'd0, 64'd6, 1'b0, 64'd0, 64'd0}
    };

    // random request, mostly set timeout near the current time so deadlines fire
    logic [63:0] clock_cyc = 0;
    task automatic random_request();
        logic [1:0]  req;
        logic [63:0] off, cyc;
        int          sel;
        sel = $urandom_range(0, 19);
        req = (sel < 11) ? REQ_SET_TMO : (sel < 16) ? REQ_CMP_IRQ :
              (sel < 19) ? REQ_GET_TIME : REQ_BAD;
        clock_cyc = clock_cyc + $urandom_range(0, 400);
        cyc = ($urandom_range(0, 15) == 0) ? rand64() : clock_cyc;
        off = ($urandom_range(0, 9) == 0) ? rand64() : 64'($urandom_range(0, 8000));
        send_request(req, 3'($urandom_range(0, 7)), off, cyc);
    endtask

    initial begin
        t_result top;
        freq_hz = HZ_RESET;
        compare_val = ONES64;
        foreach (deadlines[i]) deadlines[i] = ONES64;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table; typed rows check the done result read off directly
        foreach (directed[k]) begin
            send_request(directed[k].req, directed[k].chan, directed[k].off,
                         directed[k].now);
            if (directed[k].chk) begin
                top = pending_results[$];
                if (top.time_ns !== directed[k].t_ns || top.cmp !== directed[k].cmp) begin
                    errors++;
                    $display("%0t: row %0d table exp %h/%h predicted %h/%h", $realtime,
                             k, directed[k].t_ns, directed[k].cmp, top.time_ns, top.cmp);
                end
            end
        end
        // sender holds off until everything has come back
        drain();

        // frequency phases: extremes, zero treated as one, then typical
        write_freq(32'hFFFF_FFFF);
        send_request(REQ_GET_TIME, 3'd0, 64'd0, ONES64);
        repeat (30) random_request();
        drain();
        write_freq(32'd0);
        send_request(REQ_SET_TMO, 3'd2, 64'd1000, 64'd3);
        repeat (30) random_request();
        drain();
        write_freq(32'd1);
        repeat (30) random_request();
        drain();
        write_freq($urandom());
        repeat (30) random_request();
        drain();
        write_freq(32'd1000000000);
        repeat (30) random_request();
        quiet_phase = 1;
        repeat (30) random_request();

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
        $display("Sent %0d requests over six frequency settings; %0d results, %0d expiries.",
                 n_items, n_results, n_notify);
        if (errors == 0 && pending_results.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial begin
        #12000000;
        $display("Timeout waiting for the block");
        $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
